@@ design/cdcs_pkg.sv @@
`default_nettype none

package cdcs_pkg;

   // field widths
   localparam int PosW   = 32;
   localparam int DiffW  = 33;
   localparam int MassW  = 32;
   localparam int RestW  = 32;
   localparam int StiffW = 17;
   localparam int StepW  = 24;
   localparam int DmgW   = 24;
   localparam int RatioW = 32;

   // configuration port
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 32;
   localparam logic [CsrIdxW-1:0] CSR_REST  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_STIFF = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_BURN  = 2'd2;

   // shared arithmetic unit widths
   localparam int AccW = 128;
   localparam int OpnW = 70;
   localparam int OpdW = 83;
   localparam int RemW = 38;
   localparam int CntW = 7;

   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_DIV  = 2'd1,
      OP_SQRT = 2'd2
   } op_type;

   // command from the sequencer to the arithmetic unit
   typedef struct packed {
      logic            start;
      op_type          op;
      logic [OpdW-1:0] opd;
      logic [OpnW-1:0] opn;
      logic [CntW-1:0] count;
   } ucmd_type;

   // status from the arithmetic unit
   typedef struct packed {
      logic            done;
      logic [AccW-1:0] result;
   } ustat_type;

   // classified request held in the queue
   typedef struct packed {
      logic [2:0][DiffW-1:0] adiff;
      logic [2:0]            neg;
      logic [MassW-1:0]      m1;
      logic [MassW-1:0]      m2;
      logic                  f1;
      logic                  f2;
      logic                  fire_torn;
      logic [DmgW-1:0]       dmg;
   } job_type;

   // finished result
   typedef struct packed {
      logic [2:0][PosW-1:0] mvf;
      logic [2:0][PosW-1:0] mvs;
      logic                 torn;
      logic [RatioW-1:0]    stretch;
      logic [DmgW-1:0]      dmg;
      logic                 degenerate;
   } res_type;

endpackage

`default_nettype wire

@@ design/cdcs_if.sv @@
`default_nettype none

// request channel
interface cdcs_req_if import cdcs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [PosW-1:0]  first_x;
   logic signed [PosW-1:0]  first_y;
   logic signed [PosW-1:0]  first_z;
   logic signed [PosW-1:0]  second_x;
   logic signed [PosW-1:0]  second_y;
   logic signed [PosW-1:0]  second_z;
   logic [MassW-1:0]        first_mass;
   logic [MassW-1:0]        second_mass;
   logic                    first_fixed;
   logic                    second_fixed;
   logic [StepW-1:0]        time_step;

   modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                   first_mass, second_mass, first_fixed, second_fixed, time_step,
                   input ready);
   modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                 first_mass, second_mass, first_fixed, second_fixed, time_step,
                 output ready);
endinterface

// result channel
interface cdcs_rsp_if import cdcs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [PosW-1:0]  move_first_x;
   logic signed [PosW-1:0]  move_first_y;
   logic signed [PosW-1:0]  move_first_z;
   logic signed [PosW-1:0]  move_second_x;
   logic signed [PosW-1:0]  move_second_y;
   logic signed [PosW-1:0]  move_second_z;
   logic                    torn;
   logic [RatioW-1:0]       stretch_ratio;
   logic [DmgW-1:0]         fire_damage;
   logic                    degenerate;

   modport source (output valid, move_first_x, move_first_y, move_first_z, move_second_x,
                   move_second_y, move_second_z, torn, stretch_ratio, fire_damage,
                   degenerate, input ready);
   modport sink (input valid, move_first_x, move_first_y, move_first_z, move_second_x,
                 move_second_y, move_second_z, torn, stretch_ratio, fire_damage,
                 degenerate, output ready);
endinterface

`default_nettype wire

@@ design/cloth_distance_constraint_step_core.sv @@
`default_nettype none

// Distance constraint step between two particles in Q16.16. A request is
// classified on entry (fire damage update, difference vector) and queued; the
// back end works it on one shared bit-serial unit that multiplies, divides and
// takes the square root one result bit per cycle. A full request runs three
// squares, the root, the relative error, the stretch, two mass weights, two
// gains and three products per axis, one after another on the unit. A fire
// break skips the arithmetic in the back end, and zero length, a tear or a
// zero mass end early. The front keeps accepting while the queue has room,
// also while a finished result waits on the response channel.
module cloth_distance_constraint_step_core import cdcs_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   cdcs_req_if.sink                 req,
   cdcs_rsp_if.source               rsp,
   input  wire logic                csr_we,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata
);

   logic              q_full;
   logic              q_empty;
   logic              push;
   logic              pop;
   job_type           push_data;
   job_type           pop_data;
   logic [RestW-1:0]  rest_length;
   logic [StiffW-1:0] gain_k;
   ucmd_type          cmd;
   ustat_type         stat;

   // classify requests
   cdcs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .push        (push),
      .push_data   (push_data),
      .rest_length (rest_length),
      .gain_k      (gain_k)
   );

   // queue between front and back
   cdcs_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   // shared arithmetic
   cdcs_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   // sequencer and result register
   cdcs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .rest_length (rest_length),
      .gain_k      (gain_k),
      .cmd         (cmd),
      .stat        (stat),
      .rsp         (rsp)
   );

endmodule

`default_nettype wire

@@ design/cdcs_front.sv @@
`default_nettype none

module cdcs_front import cdcs_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   cdcs_req_if.sink                 req,
   input  wire logic                csr_we,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata,
   input  wire logic                q_full,
   output logic                     push,
   output job_type                  push_data,
   output logic [RestW-1:0]         rest_length,
   output logic [StiffW-1:0]        gain_k
);

   logic [RestW-1:0]  rest_ff;
   logic [StiffW-1:0] stiff_ff;
   logic              burn_ff;
   logic [DmgW-1:0]   dmg_ff;
   logic [DmgW-1:0]   dmg_in;
   logic [55:0]       ts_prod;
   logic [DmgW:0]     dmg_sum;
   logic [PosW-1:0]   pa [3];
   logic [PosW-1:0]   pb [3];
   logic [DiffW-1:0]  dv [3];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff  <= RestW'(65536);
         stiff_ff <= StiffW'(65536);
         burn_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REST:  rest_ff  <= csr_wdata[RestW-1:0];
            CSR_STIFF: stiff_ff <= csr_wdata[StiffW-1:0];
            CSR_BURN:  burn_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign rest_length = rest_ff;
   // gain above one is taken as one
   assign gain_k = stiff_ff[StiffW-1] ? StiffW'(65536) : stiff_ff;

   assign req.ready = !q_full;
   assign push      = req.valid && !q_full;

   // fire damage: step / 10 by reciprocal multiply
   assign ts_prod = 56'(req.time_step) * 56'(32'hCCCCCCCD);
   assign dmg_sum = {1'b0, dmg_ff} + (DmgW+1)'(ts_prod[55:35]);

   always_comb begin
      dmg_in = dmg_ff;
      if (burn_ff) begin
         dmg_in = dmg_sum[DmgW] ? {DmgW{1'b1}} : dmg_sum[DmgW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dmg_ff <= '0;
      end else if (push) begin
         dmg_ff <= dmg_in;
      end
   end

   // difference vector, magnitude and sign per axis
   assign pa[0] = req.first_x;
   assign pa[1] = req.first_y;
   assign pa[2] = req.first_z;
   assign pb[0] = req.second_x;
   assign pb[1] = req.second_y;
   assign pb[2] = req.second_z;

   always_comb begin
      push_data = '0;
      for (int i = 0; i < 3; i++) begin
         dv[i] = {pa[i][PosW-1], pa[i]} - {pb[i][PosW-1], pb[i]};
         push_data.neg[i]   = dv[i][DiffW-1];
         push_data.adiff[i] = dv[i][DiffW-1] ? (DiffW'(0) - dv[i]) : dv[i];
      end
      push_data.m1        = req.first_mass;
      push_data.m2        = req.second_mass;
      push_data.f1        = req.first_fixed;
      push_data.f2        = req.second_fixed;
      push_data.dmg       = dmg_in;
      push_data.fire_torn = burn_ff && (|dmg_in[DmgW-1:16]);
   end

endmodule

`default_nettype wire

@@ design/cdcs_fifo.sv @@
`default_nettype none

module cdcs_fifo import cdcs_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  job_type   push_data,
   output logic      full,
   input  wire logic pop,
   output job_type   pop_data,
   output logic      empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LvlW = $clog2(DEPTH + 1);

   job_type         mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ff;
   logic [PtrW-1:0] rd_ff;
   logic [LvlW-1:0] lvl_ff;

   assign full     = (lvl_ff == LvlW'(DEPTH));
   assign empty    = (lvl_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         lvl_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            lvl_ff <= lvl_ff + 1'b1;
         end else if (pop && !push) begin
            lvl_ff <= lvl_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

@@ design/cdcs_unit.sv @@
`default_nettype none

// shared bit-serial multiply, divide and square root
module cdcs_unit import cdcs_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  ucmd_type  cmd,
   output ustat_type stat
);

   op_type          op_ff;
   logic [AccW-1:0] acc_ff, acc_in;
   logic [OpnW-1:0] opn_ff, opn_in;
   logic [OpdW-1:0] opd_ff, opd_in;
   logic [RemW-1:0] rem_ff, rem_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   op_type          op_in;
   logic [RemW-1:0] div_r;
   logic [RemW+1:0] sq_r;
   logic [RemW+1:0] sq_t;

   assign div_r = {rem_ff[RemW-2:0], opn_ff[OpnW-1]};
   assign sq_r  = {rem_ff, opn_ff[OpnW-1:OpnW-2]};
   assign sq_t  = {acc_ff[RemW-1:0], 2'b01};

   always_comb begin
      acc_in  = acc_ff;
      opn_in  = opn_ff;
      opd_in  = opd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         acc_in  = '0;
         rem_in  = '0;
         opn_in  = cmd.opn;
         opd_in  = cmd.opd;
         cnt_in  = cmd.count;
         op_in   = cmd.op;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         case (op_ff)
            // shift-add, multiplier bits taken msb first
            OP_MUL: begin
               acc_in = {acc_ff[AccW-2:0], 1'b0} + (opn_ff[OpnW-1] ? AccW'(opd_ff) : '0);
               opn_in = {opn_ff[OpnW-2:0], 1'b0};
            end
            // restoring division, one quotient bit per cycle
            OP_DIV: begin
               if (div_r >= opd_ff[RemW-1:0]) begin
                  rem_in = div_r - opd_ff[RemW-1:0];
                  acc_in = {acc_ff[AccW-2:0], 1'b1};
               end else begin
                  rem_in = div_r;
                  acc_in = {acc_ff[AccW-2:0], 1'b0};
               end
               opn_in = {opn_ff[OpnW-2:0], 1'b0};
            end
            // digit-by-digit root, two operand bits per cycle
            OP_SQRT: begin
               if (sq_r >= sq_t) begin
                  rem_in = RemW'(sq_r - sq_t);
                  acc_in = {acc_ff[AccW-2:0], 1'b1};
               end else begin
                  rem_in = sq_r[RemW-1:0];
                  acc_in = {acc_ff[AccW-2:0], 1'b0};
               end
               opn_in = {opn_ff[OpnW-3:0], 2'b00};
            end
            default: ;
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      opn_ff <= opn_in;
      opd_ff <= opd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.done   = done_ff;
   assign stat.result = acc_ff;

endmodule

`default_nettype wire

@@ design/cdcs_back.sv @@
`default_nettype none

module cdcs_back import cdcs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  job_type                 pop_data,
   output logic                    pop,
   input  wire logic [RestW-1:0]   rest_length,
   input  wire logic [StiffW-1:0]  gain_k,
   output ucmd_type                cmd,
   input  ustat_type               stat,
   cdcs_rsp_if.source              rsp
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      STP_SQ   = 4'd0,
      STP_ROOT = 4'd1,
      STP_DMAG = 4'd2,
      STP_STR  = 4'd3,
      STP_W1   = 4'd4,
      STP_W2   = 4'd5,
      STP_G1   = 4'd6,
      STP_G2   = 4'd7,
      STP_PAX  = 4'd8,
      STP_MV1  = 4'd9,
      STP_MV2  = 4'd10
   } step_type;

   state_type       state_ff, state_in;
   step_type        step_ff, step_in;
   logic [1:0]      axis_ff, axis_in;
   job_type         job_ff, job_in;
   res_type         res_ff, res_in;
   logic [65:0]     sum_ff, sum_in;
   logic [34:0]     len_ff, len_in;
   logic            dneg_ff, dneg_in;
   logic [49:0]     dmag_ff, dmag_in;
   logic [32:0]     w1_ff, w1_in;
   logic [32:0]     w2_ff, w2_in;
   logic [32:0]     g1_ff, g1_in;
   logic [32:0]     g2_ff, g2_in;
   logic [82:0]     p_ff, p_in;
   logic [34:0]     mag;
   logic [33:0]     den3;
   logic [32:0]     msum;
   logic [53:0]     tear_lhs;
   logic [53:0]     tear_rhs;
   logic            mass_zero;
   logic [AccW-1:0] ures;

   // saturated signed move from the scaled product
   function automatic logic [PosW-1:0] move_sat(input logic [AccW-1:0] prod,
                                                input logic neg_dir);
      logic            big;
      logic [PosW-1:0] v;
      logic [PosW-1:0] r;
      begin
         big = |prod[AccW-1:80];
         v   = prod[79:48];
         if (neg_dir) begin
            r = (big || v > 32'h80000000) ? 32'h80000000 : (32'd0 - v);
         end else begin
            r = (big || v > 32'h7FFFFFFF) ? 32'h7FFFFFFF : v;
         end
         return r;
      end
   endfunction

   assign ures      = stat.result;
   assign mag       = dneg_ff ? (len_ff - 35'(rest_length)) : (35'(rest_length) - len_ff);
   assign den3      = {rest_length, 1'b0} + 34'(rest_length);
   assign msum      = 33'(job_ff.m1) + 33'(job_ff.m2);
   assign tear_lhs  = {1'b0, ures[49:0], 3'b000} + {3'b000, ures[49:0], 1'b0};
   assign tear_rhs  = 54'({rest_length, 4'b0000}) + 54'({rest_length, 1'b0});
   assign mass_zero = (job_ff.m1 == '0) || (job_ff.m2 == '0);

   // operand selection for the shared unit
   always_comb begin
      cmd       = '0;
      cmd.start = (state_ff == ST_ISSUE);
      case (step_ff)
         STP_SQ: begin
            cmd.op    = OP_MUL;
            cmd.opd   = OpdW'(job_ff.adiff[axis_ff]);
            cmd.opn   = {job_ff.adiff[axis_ff], 37'b0};
            cmd.count = CntW'(33);
         end
         STP_ROOT: begin
            cmd.op    = OP_SQRT;
            cmd.opn   = {4'b0, sum_ff};
            cmd.count = CntW'(35);
         end
         STP_DMAG: begin
            cmd.op    = OP_DIV;
            cmd.opd   = OpdW'(len_ff);
            cmd.opn   = {mag[32:0], 16'b0, 21'b0};
            cmd.count = CntW'(49);
         end
         STP_STR: begin
            cmd.op    = OP_DIV;
            cmd.opd   = OpdW'(den3);
            cmd.opn   = {dmag_ff, 17'b0, 3'b0};
            cmd.count = CntW'(67);
         end
         STP_W1: begin
            cmd.op    = OP_DIV;
            cmd.opd   = OpdW'(msum);
            cmd.opn   = {job_ff.m2, 32'b0, 6'b0};
            cmd.count = CntW'(64);
         end
         STP_W2: begin
            cmd.op    = OP_DIV;
            cmd.opd   = OpdW'(msum);
            cmd.opn   = {job_ff.m1, 32'b0, 6'b0};
            cmd.count = CntW'(64);
         end
         STP_G1: begin
            cmd.op    = OP_MUL;
            cmd.opd   = OpdW'(w1_ff);
            cmd.opn   = {16'b0, gain_k, 37'b0};
            cmd.count = CntW'(33);
         end
         STP_G2: begin
            cmd.op    = OP_MUL;
            cmd.opd   = OpdW'(w2_ff);
            cmd.opn   = {16'b0, gain_k, 37'b0};
            cmd.count = CntW'(33);
         end
         STP_PAX: begin
            cmd.op    = OP_MUL;
            cmd.opd   = OpdW'(dmag_ff);
            cmd.opn   = {job_ff.adiff[axis_ff], 37'b0};
            cmd.count = CntW'(33);
         end
         STP_MV1: begin
            cmd.op    = OP_MUL;
            cmd.opd   = p_ff;
            cmd.opn   = {g1_ff, 37'b0};
            cmd.count = CntW'(33);
         end
         STP_MV2: begin
            cmd.op    = OP_MUL;
            cmd.opd   = p_ff;
            cmd.opn   = {g2_ff, 37'b0};
            cmd.count = CntW'(33);
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      axis_in  = axis_ff;
      job_in   = job_ff;
      res_in   = res_ff;
      sum_in   = sum_ff;
      len_in   = len_ff;
      dneg_in  = dneg_ff;
      dmag_in  = dmag_ff;
      w1_in    = w1_ff;
      w2_in    = w2_ff;
      g1_in    = g1_ff;
      g2_in    = g2_ff;
      p_in     = p_ff;
      pop      = 1'b0;
      case (state_ff)
         // take the next request from the queue
         ST_IDLE: begin
            if (!q_empty) begin
               pop        = 1'b1;
               job_in     = pop_data;
               res_in     = '0;
               res_in.dmg = pop_data.dmg;
               sum_in     = '0;
               axis_in    = '0;
               step_in    = STP_SQ;
               if (pop_data.fire_torn) begin
                  res_in.torn = 1'b1;
                  state_in    = ST_OUT;
               end else begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         // consume the unit result and pick the next step
         ST_WAIT: begin
            if (stat.done) begin
               state_in = ST_ISSUE;
               case (step_ff)
                  STP_SQ: begin
                     sum_in = sum_ff + ures[65:0];
                     if (axis_ff == 2'd2) begin
                        step_in = STP_ROOT;
                     end else begin
                        axis_in = axis_ff + 1'b1;
                     end
                  end
                  STP_ROOT: begin
                     len_in  = ures[34:0];
                     dneg_in = 35'(rest_length) < ures[34:0];
                     if (ures[34:0] == '0) begin
                        res_in.degenerate = 1'b1;
                        state_in          = ST_OUT;
                     end else begin
                        step_in = STP_DMAG;
                     end
                  end
                  STP_DMAG: begin
                     dmag_in = ures[49:0];
                     if (!dneg_ff && tear_lhs >= tear_rhs) begin
                        res_in.torn = 1'b1;
                        state_in    = ST_OUT;
                     end else if (rest_length == '0) begin
                        res_in.stretch = {RatioW{1'b1}};
                        if (mass_zero) begin
                           res_in.degenerate = 1'b1;
                           state_in          = ST_OUT;
                        end else begin
                           step_in = STP_W1;
                        end
                     end else begin
                        step_in = STP_STR;
                     end
                  end
                  STP_STR: begin
                     res_in.stretch = (|ures[AccW-1:32]) ? {RatioW{1'b1}} : ures[31:0];
                     if (mass_zero) begin
                        res_in.degenerate = 1'b1;
                        state_in          = ST_OUT;
                     end else begin
                        step_in = STP_W1;
                     end
                  end
                  STP_W1: begin
                     w1_in   = ures[32:0];
                     step_in = STP_W2;
                  end
                  STP_W2: begin
                     w2_in   = ures[32:0];
                     step_in = STP_G1;
                  end
                  STP_G1: begin
                     g1_in   = ures[48:16];
                     step_in = STP_G2;
                  end
                  STP_G2: begin
                     g2_in   = ures[48:16];
                     axis_in = '0;
                     step_in = STP_PAX;
                  end
                  STP_PAX: begin
                     p_in    = ures[82:0];
                     step_in = STP_MV1;
                  end
                  STP_MV1: begin
                     if (!job_ff.f1) begin
                        res_in.mvf[axis_ff] = move_sat(ures, job_ff.neg[axis_ff] != dneg_ff);
                     end
                     step_in = STP_MV2;
                  end
                  STP_MV2: begin
                     if (!job_ff.f2) begin
                        res_in.mvs[axis_ff] = move_sat(ures, job_ff.neg[axis_ff] == dneg_ff);
                     end
                     if (axis_ff == 2'd2) begin
                        state_in = ST_OUT;
                     end else begin
                        axis_in = axis_ff + 1'b1;
                        step_in = STP_PAX;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // hold the result until it is taken
         ST_OUT: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STP_SQ;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         axis_ff  <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      res_ff  <= res_in;
      sum_ff  <= sum_in;
      len_ff  <= len_in;
      dneg_ff <= dneg_in;
      dmag_ff <= dmag_in;
      w1_ff   <= w1_in;
      w2_ff   <= w2_in;
      g1_ff   <= g1_in;
      g2_ff   <= g2_in;
      p_ff    <= p_in;
   end

   // result channel
   assign rsp.valid         = (state_ff == ST_OUT);
   assign rsp.move_first_x  = res_ff.mvf[0];
   assign rsp.move_first_y  = res_ff.mvf[1];
   assign rsp.move_first_z  = res_ff.mvf[2];
   assign rsp.move_second_x = res_ff.mvs[0];
   assign rsp.move_second_y = res_ff.mvs[1];
   assign rsp.move_second_z = res_ff.mvs[2];
   assign rsp.torn          = res_ff.torn;
   assign rsp.stretch_ratio = res_ff.stretch;
   assign rsp.fire_damage   = res_ff.dmg;
   assign rsp.degenerate    = res_ff.degenerate;

endmodule

`default_nettype wire

@@ design/cdcs_checker.sv @@
`default_nettype none

module cdcs_checker import cdcs_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               torn,
   input wire logic               degenerate,
   input wire logic [RatioW-1:0]  stretch_ratio,
   input wire logic [6*PosW-1:0]  moves
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response keeps its moves
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(moves))
      else $error("stalled response changed");

   // a torn constraint moves nothing and reports no stretch
   a_torn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && torn |-> moves == '0 && stretch_ratio == '0 && !degenerate)
      else $error("torn response carries moves");

   // a degenerate constraint moves nothing and is not torn
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && degenerate |-> moves == '0 && !torn)
      else $error("degenerate response carries moves");

endmodule

bind cloth_distance_constraint_step_core cdcs_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .torn          (rsp.torn),
   .degenerate    (rsp.degenerate),
   .stretch_ratio (rsp.stretch_ratio),
   .moves         ({rsp.move_first_x, rsp.move_first_y, rsp.move_first_z,
                    rsp.move_second_x, rsp.move_second_y, rsp.move_second_z})
);

`default_nettype wire
